// ===== rtl/fcs_pkg.sv =====
// Package for the feedback comb with shelf unit.
// Holds the input op codes, the configuration register indexes and the controller command and status types.
package fcs_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam logic [2:0] REG_MAIN_DELAY    = 3'd0;
    localparam logic [2:0] REG_AUX_DELAY     = 3'd1;
    localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd2;
    localparam logic [2:0] REG_TILT_AMOUNT   = 3'd3;
    localparam logic [2:0] REG_SHELF_COEF    = 3'd4;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_CLIP  = 5'b01000,
        ST_OUT   = 5'b10000
    } fcs_state_t;

    typedef struct packed {
        logic clear_step;
        logic clear_start;
        logic load;
        logic run_step;
        logic clip_start;
        logic out_load;
    } fcs_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic run_done;
        logic clip_done;
    } fcs_status_t;

endpackage

// ===== rtl/fcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the delay ring. No dependencies.
module fcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/fcs_ctrl.sv =====
// Controller state machine of the feedback comb with shelf unit.
// Depends on fcs_pkg for the state, command and status types.
module fcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    input  logic                 out_free,
    input  fcs_pkg::fcs_status_t status,
    output fcs_pkg::fcs_cmd_t    cmd,
    output logic                 in_ready
);
    import fcs_pkg::*;

    fcs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_RESET)
                    begin
                        cmd.clear_start = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.run_step = 1'b1;
                if (status.run_done)
                begin
                    cmd.clip_start = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                if (status.clip_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end
endmodule

// ===== rtl/fcs_div.sv =====
// Bit-serial restoring divider used by the soft clip, one quotient bit a cycle.
// No dependencies beyond its parameters.
module fcs_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1)) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                r_reg <= diff[DW:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;
endmodule

// ===== rtl/fcs_dp.sv =====
// Datapath of the feedback comb with shelf unit: delay ring, shelf, write-back and soft clip.
// Depends on fcs_pkg, fcs_ram and fcs_div.
module fcs_dp #(
    parameter int LINE_DEPTH = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcs_pkg::fcs_cmd_t    cmd,
    output fcs_pkg::fcs_status_t status,
    input  logic signed [15:0]   exciter_sample,
    input  logic [19:0]          main_delay,
    input  logic [19:0]          aux_delay,
    input  logic signed [15:0]   feedback_gain,
    input  logic signed [15:0]   tilt_amount,
    input  logic [14:0]          shelf_coef,
    output logic [15:0]          main_out,
    output logic [15:0]          aux_out
);
    import fcs_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int TW = 16 + FRAC_BITS + 2;
    localparam int SHL = (FRAC_BITS <= 8) ? 8 - FRAC_BITS : 0;
    localparam int SHR = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
    localparam int SHRR = (SHR > 0) ? SHR : 1;
    localparam int NW = 64;
    localparam int DW = 34;
    localparam int ONE = 8388608;

    logic [AW-1:0] wpos_reg, caddr_reg;
    logic [AW:0]   ccnt_reg;
    logic [3:0]    step_reg;
    logic signed [23:0] shelf_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] a_reg;
    logic signed [31:0] dm_reg, da_reg, s_reg, t_reg;
    logic signed [63:0] p_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;
    logic [19:0]   dsel;
    logic [AW-1:0] off;
    logic signed [31:0] tap_q23;
    logic signed [TW-1:0] tap_v;
    logic signed [FRAC_BITS:0] frac_s;

    fcs_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    function automatic logic signed [31:0] rsh15(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = (v + 64'sd16384) >>> 15;
            rsh15 = t[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clampw(input logic signed [31:0] v,
                                                  input logic signed [31:0] hi);
        begin
            if (v < -32'sd8388608)
            begin
                clampw = -32'sd8388608;
            end
            else if (v > hi)
            begin
                clampw = hi;
            end
            else
            begin
                clampw = v;
            end
        end
    endfunction

    // Tap read address: steps 0,1 main (newer, older), 2,3 aux.
    // The main tap is interpolated in step 2 and the aux tap in step 4.
    assign dsel = (step_reg < 4'd2) ? main_delay : aux_delay;
    assign off = wpos_reg - AW'(dsel >> FRAC_BITS) -
                 AW'(step_reg[0]);
    assign frac_s = $signed({1'b0, (step_reg == 4'd2) ? main_delay[FRAC_BITS-1:0]
                                                      : aux_delay[FRAC_BITS-1:0]});
    assign tap_v = TW'(a_reg) * $signed(TW'(1) <<< FRAC_BITS) +
                   (TW'($signed(ram_rdata)) - TW'(a_reg)) * TW'(frac_s);

    generate
        if (FRAC_BITS <= 8)
        begin : g_shl
            assign tap_q23 = 32'(tap_v) <<< SHL;
        end
        else
        begin : g_shr
            assign tap_q23 = 32'((tap_v + (TW'(1) <<< (SHRR - 1))) >>> SHRR);
        end
    endgenerate

    // Write-back and clear port.
    logic signed [31:0] w_cl;
    logic [31:0]        w_mag;
    logic [47:0]        w_prod;
    assign w_cl = clampw(t_reg, 32'sd8388608);
    assign w_mag = w_cl[31] ? 32'(-w_cl) : 32'(w_cl);
    assign w_prod = 48'(w_mag) * 48'd32767;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = wpos_reg;
        ram_wdata = '0;
        ram_raddr = off;
        if (!ccnt_reg[AW] || cmd.clear_start)
        begin
            ram_we = cmd.clear_step;
            ram_waddr = caddr_reg;
        end
        if (cmd.run_step && step_reg == 4'd9)
        begin
            ram_we = 1'b1;
            ram_wdata = w_cl[31] ? 16'(-w_prod[38:23]) : w_prod[38:23];
        end
    end

    assign status.clear_done = ccnt_reg[AW];
    assign status.run_done = cmd.run_step && step_reg == 4'd9;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccnt_reg  <= '0;
            caddr_reg <= '0;
            wpos_reg  <= '0;
            shelf_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                ccnt_reg  <= '0;
                caddr_reg <= '0;
                wpos_reg  <= '0;
                shelf_reg <= '0;
            end
            else if (cmd.clear_step && !ccnt_reg[AW])
            begin
                ccnt_reg  <= ccnt_reg + 1'b1;
                caddr_reg <= caddr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.run_step)
            begin
                step_reg <= (step_reg == 4'd9) ? 4'd0 : step_reg + 1'b1;
                if (step_reg == 4'd5)
                begin
                    shelf_reg <= 24'(clampw(s_reg + rsh15(p_reg), 32'sd8388607));
                end
                if (step_reg == 4'd9)
                begin
                    wpos_reg <= wpos_reg + 1'b1;
                end
            end
        end
    end

    // Sequenced arithmetic, the multiplies spread over the run steps.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= exciter_sample;
        end
        if (cmd.run_step)
        begin
            case (step_reg)
                4'd1: a_reg <= $signed(ram_rdata);
                4'd2: dm_reg <= tap_q23;
                4'd3: a_reg <= $signed(ram_rdata);
                4'd4:
                begin
                    da_reg <= tap_q23;
                    s_reg <= 32'(shelf_reg);
                    p_reg <= 64'(dm_reg - 32'(shelf_reg)) * $signed({49'b0, shelf_coef});
                end
                4'd6:
                begin
                    p_reg <= 64'(32'(shelf_reg) - dm_reg) * 64'(tilt_amount);
                end
                4'd7:
                begin
                    t_reg <= dm_reg + rsh15(p_reg);
                end
                4'd8:
                begin
                    t_reg <= rsh15(64'(t_reg) * 64'(feedback_gain)) +
                             (32'(x_reg) <<< 7);
                end
                default: ;
            endcase
        end
    end

    // Soft clip: two passes over one shared divider, main then aux.
    logic        cphase_reg, cbusy_reg, dstart_reg;
    logic [3:0]  cstep_reg;
    logic signed [31:0] cx_reg;
    logic signed [63:0] cm_reg;
    logic signed [31:0] cx2_reg;
    logic        cneg_reg, csat_reg;
    logic signed [63:0] cnum_reg;
    logic [DW-1:0] cden_reg;
    logic [NW-1:0] dquo;
    logic        ddone;
    logic signed [31:0] y_val;
    logic signed [31:0] y_r;
    logic [15:0] y_out;
    logic [15:0] main_reg;

    fcs_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart_reg),
        .num(64'(cnum_reg[63] ? -cnum_reg : cnum_reg) + 64'(cden_reg >> 1)),
        .den(cden_reg), .quo(dquo), .done(ddone)
    );

    always_comb
    begin
        if (csat_reg)
        begin
            y_val = (cx_reg[31]) ? -32'sd8388608 : 32'sd8388608;
        end
        else
        begin
            y_val = cneg_reg ? -32'(dquo) : 32'(dquo);
        end
        y_r = (y_val + 32'sd128) >>> 8;
        if (y_r > 32'sd32767)
        begin
            y_out = 16'h7fff;
        end
        else if (y_r < -32'sd32768)
        begin
            y_out = 16'h8000;
        end
        else
        begin
            y_out = y_r[15:0];
        end
    end

    assign status.clip_done = cbusy_reg && cphase_reg && cstep_reg == 4'd4 &&
                              (csat_reg || ddone);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbusy_reg  <= 1'b0;
            cphase_reg <= 1'b0;
            cstep_reg  <= '0;
            dstart_reg <= 1'b0;
        end
        else
        begin
            dstart_reg <= 1'b0;
            if (cmd.clip_start)
            begin
                cbusy_reg  <= 1'b1;
                cphase_reg <= 1'b0;
                cstep_reg  <= '0;
            end
            else if (cbusy_reg)
            begin
                if (cstep_reg < 4'd3)
                begin
                    cstep_reg <= cstep_reg + 1'b1;
                end
                else if (cstep_reg == 4'd3)
                begin
                    cstep_reg <= 4'd4;
                    dstart_reg <= !csat_reg;
                end
                else if (csat_reg || ddone)
                begin
                    cstep_reg <= '0;
                    cphase_reg <= 1'b1;
                    if (cphase_reg)
                    begin
                        cbusy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cbusy_reg)
        begin
            case (cstep_reg)
                4'd0:
                begin
                    cx_reg <= (32'(x_reg) <<< 7) + (cphase_reg ? da_reg : dm_reg);
                end
                4'd1:
                begin
                    cm_reg <= 64'(cx_reg) * 64'(cx_reg);
                    csat_reg <= cx_reg > 32'sd25165824 || cx_reg < -32'sd25165824;
                    cneg_reg <= 1'b0;
                end
                4'd2:
                begin
                    cx2_reg <= 32'((cm_reg + 64'sd4194304) >>> 23);
                end
                4'd3:
                begin
                    cnum_reg <= 64'(cx_reg) * (64'sd226492416 + 64'(cx2_reg));
                    cden_reg <= DW'(64'sd226492416 + 64'sd9 * 64'(cx2_reg));
                    cneg_reg <= cx_reg[31];
                end
                4'd4:
                begin
                    if ((csat_reg || ddone) && !cphase_reg)
                    begin
                        main_reg <= y_out;
                    end
                end
                default: ;
            endcase
        end
    end

    assign main_out = main_reg;
    assign aux_out = y_out;
    logic unused_one;
    assign unused_one = (ONE == 0);
endmodule

// ===== rtl/feedback_comb_with_shelf_unit.sv =====
// Top level of the feedback comb with shelf unit.
// Depends on fcs_pkg, fcs_ctrl and fcs_dp, which holds the ring RAM and the soft-clip divider.
//
// The slave stream carries one transaction per audio sample: tdata holds the exciter sample
// and tuser holds op (0 processes a sample, 1 clears the ring, pointer and shelf).
// A processed sample yields one master transaction with main_out in tdata[15:0] and
// aux_out in tdata[31:16]; a reset item yields none.
// Configuration is a plain write port: registers 0 to 4 are main_delay, aux_delay,
// feedback_gain, tilt_amount and shelf_coef.
// One item at a time is processed. A sample takes 10 sequencer steps for the two tap
// reads, shelf and write-back, then two soft-clip passes over the shared bit-serial
// divider, each made of 4 steps, a divider start, the bit-serial division and a done;
// a pass that saturates skips the divider and finishes after its 4 steps.
// A reset item, and the asynchronous reset, start a clearing pass over the ring during
// which no item is accepted.
// The result waits in an output register; if the receiver stalls, the next sample is still
// accepted and computed, and then waits until the held result has been taken.
module feedback_comb_with_shelf_unit #(
    parameter int LINE_DEPTH = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // exciter_sample
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // main_out, aux_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import fcs_pkg::*;

    logic [19:0] main_delay_reg, aux_delay_reg;
    logic signed [15:0] feedback_gain_reg, tilt_amount_reg;
    logic [14:0] shelf_coef_reg;
    fcs_cmd_t cmd;
    fcs_status_t status;
    logic [15:0] main_out, aux_out;
    logic out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_delay_reg    <= 20'd25600;
            aux_delay_reg     <= 20'd38400;
            feedback_gain_reg <= '0;
            tilt_amount_reg   <= '0;
            shelf_coef_reg    <= 15'd16384;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAIN_DELAY:    main_delay_reg    <= cfg_data;
                REG_AUX_DELAY:     aux_delay_reg     <= cfg_data;
                REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[15:0];
                REG_TILT_AMOUNT:   tilt_amount_reg   <= cfg_data[15:0];
                REG_SHELF_COEF:    shelf_coef_reg    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_tvalid || m_tready;

    fcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_op(s_tuser),
        .out_free(out_free), .status(status), .cmd(cmd), .in_ready(s_tready)
    );

    fcs_dp #(.LINE_DEPTH(LINE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .exciter_sample(s_tdata), .main_delay(main_delay_reg),
        .aux_delay(aux_delay_reg), .feedback_gain(feedback_gain_reg),
        .tilt_amount(tilt_amount_reg), .shelf_coef(shelf_coef_reg),
        .main_out(main_out), .aux_out(aux_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata <= {aux_out, main_out};
        end
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free) else $error("result loaded over a held one");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.run_step || cmd.clear_step) |-> !s_tready) else $error("accept while busy");
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid) else $error("result not presented");
`endif
endmodule
